[design/tmcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree mesh child table router: shared definitions
// Field widths, command and result codes, register indexes and hop helpers.
// ----------------------------------------------------------------------------
package tmcr_pkg;

	localparam int MAX_CHILDREN_DEF = 6;
	localparam int MAX_HOPS         = 5;

	localparam int MAC_W   = 48;
	localparam int HOP_W   = 3;
	localparam int NHOPS   = 5;
	localparam int PATH_W  = HOP_W * NHOPS;
	localparam int CNT_W   = 3;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 32;
	localparam int CFG_W   = 64;
	localparam int ADDR_W  = 4;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_ROUTE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_DELIVER = 2'd0,
		ACT_PARENT  = 2'd1,
		ACT_CHILD   = 2'd2,
		ACT_DROP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		WHY_NONE      = 2'd0,
		WHY_NOT_BOUND = 2'd1,
		WHY_BAD       = 2'd2,
		WHY_NO_CHILD  = 2'd3
	} drop_t;

	// Register indexes; the register at index i sits at byte address 8*i.
	localparam logic REG_HAS_PARENT = 1'b0;
	localparam logic REG_PARENT_MAC = 1'b1;

	// Keep the first n hops of a packed path and clear the rest.
	function automatic logic [PATH_W-1:0] keep_hops(input logic [PATH_W-1:0] hops,
			input logic [2:0] n);
		logic [PATH_W-1:0] mask;
		mask = '0;
		for (int k = 0; k < NHOPS; k++) begin
			if (k < int'(n)) begin
				mask[k*HOP_W +: HOP_W] = '1;
			end
		end
		return hops & mask;
	endfunction

endpackage

[design/tree_mesh_child_table_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree mesh child table router
// Keeps the child slot table of a mesh node and routes frames by sender MAC.
// ----------------------------------------------------------------------------
// Add and route read the MAC memory once per slot, then pass one compare stage and the
// decision state; remove and clear go straight to the decision state.
// One item is in work at a time: the next input transfer is taken only after the result
// of the last one is registered, and that waits while an earlier result waits for the
// output side. Reset empties the table, clears the registers and the output; the MAC
// memory is not cleared, since entries are only trusted while valid.
module tree_mesh_child_table_router #(
	parameter int MAX_CHILDREN = tmcr_pkg::MAX_CHILDREN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmcr_pkg::ADDR_W-1:0] paddr,
	input  logic [tmcr_pkg::CFG_W-1:0]  pwdata,
	output logic [tmcr_pkg::CFG_W-1:0]  prdata,
	output logic                        pready,
	// Command stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// child_index[2:0], peer_mac[50:3], upstream[51], path_length[54:52],
	// path_hops[69:55], zero pad[71:70]
	input  logic [tmcr_pkg::IN_W-1:0]   s_tdata,
	// command[1:0]
	input  logic [1:0]                  s_tuser,
	// Result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// accepted[0], action[2:1], drop_reason[4:3], hop_index[7:5],
	// new_path_length[10:8], new_path_hops[25:11], child_count[28:26],
	// table_full[29], zero pad[31:30]
	output logic [tmcr_pkg::OUT_W-1:0]  m_tdata
);

	localparam int SLOT_AW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
	localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(MAX_CHILDREN - 1);
	localparam logic [2:0] CAP_FULL = 3'(MAX_CHILDREN);
	localparam logic [3:0] HOPS_LIM = 4'(tmcr_pkg::MAX_HOPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic                       has_parent_q;
	logic [tmcr_pkg::MAC_W-1:0] parent_mac_q;

	// Current item
	tmcr_pkg::cmd_t              cmd_q;
	logic [2:0]                  idx_q;
	logic [tmcr_pkg::MAC_W-1:0]  mac_q;
	logic                        up_q;
	logic [2:0]                  plen_q;
	logic [tmcr_pkg::PATH_W-1:0] phops_q;

	// Table state
	logic [MAX_CHILDREN-1:0]     valid_q;
	logic [tmcr_pkg::CNT_W-1:0]  count_q;

	// Scan
	logic [SLOT_AW-1:0]          scan_q;
	logic                        rd_s1;
	logic [SLOT_AW-1:0]          rd_idx_s1;
	logic [2:0]                  found_q;
	logic [tmcr_pkg::MAC_W-1:0]  rd_data;

	logic                        m_tvalid_q;
	logic [tmcr_pkg::OUT_W-1:0]  m_tdata_q;

	// ------------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------------
	logic cfg_wr;
	logic cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	// Only bit 3 is decoded; the two registers sit at byte addresses 0 and 8.
	assign cfg_sel = paddr[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_parent_q <= 1'b0;
			parent_mac_q <= '0;
		end else if (cfg_wr) begin
			if (cfg_sel == tmcr_pkg::REG_HAS_PARENT) begin
				has_parent_q <= pwdata[0];
			end else begin
				parent_mac_q <= pwdata[tmcr_pkg::MAC_W-1:0];
			end
		end
	end

	always_comb begin
		if (cfg_sel == tmcr_pkg::REG_PARENT_MAC) begin
			prdata = {{(tmcr_pkg::CFG_W - tmcr_pkg::MAC_W){1'b0}}, parent_mac_q};
		end else begin
			prdata = {{(tmcr_pkg::CFG_W - 1){1'b0}}, has_parent_q};
		end
	end

	// ------------------------------------------------------------------------
	// MAC memory
	// ------------------------------------------------------------------------
	logic               in_fire;
	logic               scan_rd;
	logic               out_free;
	logic               done_fire;
	logic               mem_wr;
	logic [SLOT_AW-1:0] idx_slot;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign scan_rd   = (state_q == ST_SCAN);
	assign out_free  = !m_tvalid_q || m_tready;
	assign done_fire = (state_q == ST_DONE) && out_free;
	assign idx_slot  = SLOT_AW'(idx_q - 3'd1);

	tmcr_mac_ram #(
		.DEPTH (MAX_CHILDREN),
		.AW    (SLOT_AW)
	) u_mac_ram (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (idx_slot),
		.wr_data (mac_q),
		.rd_en   (scan_rd),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------------
	// Decision
	// ------------------------------------------------------------------------
	logic [2:0]                  cap;
	logic                        idx_in_range;
	logic                        idx_taken;
	logic                        add_ok;
	logic                        rem_ok;
	logic                        from_parent;
	logic [2:0]                  first_hop;
	logic [SLOT_AW-1:0]          first_slot;
	logic                        first_ok;
	logic                        acc;
	tmcr_pkg::action_t           act;
	tmcr_pkg::drop_t             why;
	logic [2:0]                  hop;
	logic [2:0]                  nlen;
	logic [tmcr_pkg::PATH_W-1:0] nhops;
	logic [MAX_CHILDREN-1:0]     valid_nx;
	logic [tmcr_pkg::CNT_W-1:0]  count_nx;
	logic                        full_nx;

	assign cap          = has_parent_q ? (CAP_FULL - 3'd1) : CAP_FULL;
	assign idx_in_range = (idx_q != 3'd0) && (idx_q <= CAP_FULL);
	assign idx_taken    = idx_in_range ? valid_q[idx_slot] : 1'b0;
	assign add_ok       = (count_q < cap) && idx_in_range && !idx_taken && (found_q == 3'd0);
	assign rem_ok       = idx_taken;
	assign from_parent  = has_parent_q && (mac_q == parent_mac_q);
	assign first_hop    = phops_q[2:0];
	assign first_slot   = SLOT_AW'(first_hop - 3'd1);
	assign first_ok     = (first_hop != 3'd0) && (first_hop <= CAP_FULL) &&
			valid_q[first_slot];
	assign mem_wr       = done_fire && (cmd_q == tmcr_pkg::CMD_ADD) && add_ok;

	always_comb begin
		acc      = 1'b0;
		act      = tmcr_pkg::ACT_DELIVER;
		why      = tmcr_pkg::WHY_NONE;
		hop      = 3'd0;
		nlen     = 3'd0;
		nhops    = '0;
		valid_nx = valid_q;
		count_nx = count_q;
		case (cmd_q)
			tmcr_pkg::CMD_ADD: begin
				if (add_ok) begin
					valid_nx[idx_slot] = 1'b1;
					count_nx           = count_q + 3'd1;
					acc                = 1'b1;
				end
			end
			tmcr_pkg::CMD_REMOVE: begin
				if (rem_ok) begin
					valid_nx[idx_slot] = 1'b0;
					count_nx           = count_q - 3'd1;
					acc                = 1'b1;
				end
			end
			tmcr_pkg::CMD_CLEAR: begin
				valid_nx = '0;
				count_nx = '0;
				acc      = 1'b1;
			end
			tmcr_pkg::CMD_ROUTE: begin
				nlen  = plen_q;
				nhops = tmcr_pkg::keep_hops(phops_q, plen_q);
				act   = tmcr_pkg::ACT_DROP;
				if (!from_parent && found_q == 3'd0) begin
					why = tmcr_pkg::WHY_NOT_BOUND;
				end else if (up_q) begin
					// A sender that is both parent and child counts as the child here.
					if (found_q == 3'd0) begin
						why = tmcr_pkg::WHY_BAD;
					end else if ({1'b0, plen_q} >= HOPS_LIM) begin
						why = tmcr_pkg::WHY_BAD;
						hop = found_q;
					end else begin
						nhops = {nhops[tmcr_pkg::PATH_W-tmcr_pkg::HOP_W-1:0], found_q};
						nlen  = plen_q + 3'd1;
						act   = has_parent_q ? tmcr_pkg::ACT_PARENT : tmcr_pkg::ACT_DELIVER;
						acc   = 1'b1;
					end
				end else if (!from_parent) begin
					why = tmcr_pkg::WHY_BAD;
				end else if ({1'b0, plen_q} > HOPS_LIM) begin
					why = tmcr_pkg::WHY_BAD;
				end else if (plen_q == 3'd0) begin
					act = tmcr_pkg::ACT_DELIVER;
					acc = 1'b1;
				end else if (!first_ok) begin
					why = tmcr_pkg::WHY_NO_CHILD;
					hop = first_hop;
				end else begin
					nlen  = plen_q - 3'd1;
					nhops = tmcr_pkg::keep_hops(nhops >> tmcr_pkg::HOP_W, plen_q - 3'd1);
					act   = tmcr_pkg::ACT_CHILD;
					hop   = first_hop;
					acc   = 1'b1;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase
		full_nx = (count_nx >= cap);
	end

	// ------------------------------------------------------------------------
	// Control and state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= tmcr_pkg::CMD_ADD;
			idx_q      <= '0;
			mac_q      <= '0;
			up_q       <= 1'b0;
			plen_q     <= '0;
			phops_q    <= '0;
			valid_q    <= '0;
			count_q    <= '0;
			scan_q     <= '0;
			rd_s1      <= 1'b0;
			rd_idx_s1  <= '0;
			found_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			rd_s1     <= scan_rd;
			rd_idx_s1 <= scan_q;

			// Slots are scanned in ascending order, so the first hit is kept.
			if (rd_s1 && found_q == 3'd0 && valid_q[rd_idx_s1] && rd_data == mac_q) begin
				found_q <= 3'(rd_idx_s1) + 3'd1;
			end

			if (m_tvalid_q && m_tready && !done_fire) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cmd_q   <= tmcr_pkg::cmd_t'(s_tuser);
						idx_q   <= s_tdata[2:0];
						mac_q   <= s_tdata[50:3];
						up_q    <= s_tdata[51];
						plen_q  <= s_tdata[54:52];
						phops_q <= s_tdata[69:55];
						scan_q  <= '0;
						found_q <= '0;
						if (tmcr_pkg::cmd_t'(s_tuser) == tmcr_pkg::CMD_ADD ||
								tmcr_pkg::cmd_t'(s_tuser) == tmcr_pkg::CMD_ROUTE) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q == LAST_SLOT) begin
						state_q <= ST_LAST;
					end else begin
						scan_q <= scan_q + SLOT_AW'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						valid_q    <= valid_nx;
						count_q    <= count_nx;
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {2'b00, full_nx, count_nx, nhops, nlen, hop,
								why, act, acc};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
			int'(count_q) == $countones(valid_q))
		else $error("bound count differs from number of valid slots");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
			$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a decision cycle");

	a_no_accept_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_SCAN || state_q == ST_LAST) |=> !$past(in_fire))
		else $error("input taken while a table scan was running");

	a_found_is_valid: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_DONE && found_q != 3'd0) |->
			valid_q[SLOT_AW'(found_q - 3'd1)])
		else $error("matched slot is not bound");

endmodule

[design/tmcr_mac_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Child MAC store
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tmcr_mac_ram #(
	parameter int DEPTH = tmcr_pkg::MAX_CHILDREN_DEF,
	parameter int AW    = 3
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [tmcr_pkg::MAC_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [tmcr_pkg::MAC_W-1:0] rd_data
);

	logic [tmcr_pkg::MAC_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[tb/sv/tb_tree_mesh_child_table_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tree mesh child table router testbench
// Drives add, remove, clear and route commands into the command stream.
// A local copy of the child table computes the routing decision for each
// accepted transfer. Every result transfer is compared field by field with
// the oldest pending decision. Both stream sides idle at random. The result
// side also holds off for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_tree_mesh_child_table_router;

	localparam int CHILD_SLOTS = tmcr_pkg::MAX_CHILDREN_DEF;
	localparam int HOP_LIMIT   = tmcr_pkg::MAX_HOPS;
	localparam logic [47:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic              accepted;
		tmcr_pkg::action_t action;
		tmcr_pkg::drop_t   reason;
		logic [2:0]        hop;
		logic [2:0]        path_len;
		logic [14:0]       path;
		logic [2:0]        count;
		logic              full;
	} decision_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [tmcr_pkg::ADDR_W-1:0] paddr;
	logic [tmcr_pkg::CFG_W-1:0]  pwdata;
	logic [tmcr_pkg::CFG_W-1:0]  prdata;
	logic                        pready;
	logic                        s_tvalid;
	logic                        s_tready;
	// child_index[2:0], peer_mac[50:3], upstream[51], path_length[54:52],
	// path_hops[69:55], zero pad[71:70]
	logic [tmcr_pkg::IN_W-1:0]   s_tdata;
	// command[1:0]
	logic [1:0]                  s_tuser;
	logic                        m_tvalid;
	logic                        m_tready;
	// accepted[0], action[2:1], drop_reason[4:3], hop_index[7:5],
	// new_path_length[10:8], new_path_hops[25:11], child_count[28:26],
	// table_full[29], zero pad[31:30]
	logic [tmcr_pkg::OUT_W-1:0]  m_tdata;

	// Local copy of the node registers and the child table.
	bit          node_has_parent = 1'b0;
	bit [47:0]   node_parent_mac = '0;
	bit          slot_used [CHILD_SLOTS];
	bit [47:0]   slot_addr [CHILD_SLOTS];
	int          slot_count = 0;

	decision_t   pending_decisions [$];
	int          mismatches = 0;
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int          rx_hold = 0;

	tree_mesh_child_table_router uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic int owner_slot(input logic [47:0] mac);
		for (int k = 0; k < CHILD_SLOTS; k++) begin
			if (slot_used[k] && slot_addr[k] == mac) begin
				return k + 1;
			end
		end
		return 0;
	endfunction

	function automatic logic [14:0] trim_path(input logic [14:0] hops, input logic [2:0] n);
		logic [31:0] mask;
		mask = (32'd1 << (3 * n)) - 32'd1;
		return hops & mask[14:0];
	endfunction

	// Applies one command to the local table and returns the routing decision.
	function automatic decision_t router_decision(input tmcr_pkg::cmd_t c,
			input logic [2:0] idx, input logic [47:0] mac, input logic up,
			input logic [2:0] plen, input logic [14:0] hops);
		decision_t  d;
		int         cap;
		int         sender;
		logic       from_parent;
		logic [2:0] first;
		d = '0;
		cap = node_has_parent ? CHILD_SLOTS - 1 : CHILD_SLOTS;
		case (c)
			tmcr_pkg::CMD_ADD: begin
				if (slot_count < cap && idx >= 1 && idx <= CHILD_SLOTS &&
						!slot_used[idx - 1] && owner_slot(mac) == 0) begin
					slot_used[idx - 1] = 1'b1;
					slot_addr[idx - 1] = mac;
					slot_count++;
					d.accepted = 1'b1;
				end
			end
			tmcr_pkg::CMD_REMOVE: begin
				if (idx >= 1 && idx <= CHILD_SLOTS && slot_used[idx - 1]) begin
					slot_used[idx - 1] = 1'b0;
					slot_count--;
					d.accepted = 1'b1;
				end
			end
			tmcr_pkg::CMD_CLEAR: begin
				slot_used = '{default: 1'b0};
				slot_count = 0;
				d.accepted = 1'b1;
			end
			default: begin
				from_parent = node_has_parent && mac == node_parent_mac;
				sender = owner_slot(mac);
				d.path_len = plen;
				d.path = trim_path(hops, plen);
				d.action = tmcr_pkg::ACT_DROP;
				if (!from_parent && sender == 0) begin
					d.reason = tmcr_pkg::WHY_NOT_BOUND;
				end else if (up) begin
					// A sender that is both parent and child counts as the child here.
					if (sender == 0) begin
						d.reason = tmcr_pkg::WHY_BAD;
					end else if (plen >= HOP_LIMIT) begin
						d.reason = tmcr_pkg::WHY_BAD;
						d.hop = 3'(sender);
					end else begin
						d.path = {d.path[11:0], 3'(sender)};
						d.path_len = plen + 3'd1;
						d.action = node_has_parent ? tmcr_pkg::ACT_PARENT
							: tmcr_pkg::ACT_DELIVER;
						d.accepted = 1'b1;
					end
				end else if (!from_parent) begin
					d.reason = tmcr_pkg::WHY_BAD;
				end else if (plen > HOP_LIMIT) begin
					d.reason = tmcr_pkg::WHY_BAD;
				end else if (plen == 0) begin
					d.action = tmcr_pkg::ACT_DELIVER;
					d.accepted = 1'b1;
				end else begin
					first = d.path[2:0];
					if (first == 0 || first > CHILD_SLOTS || !slot_used[first - 1]) begin
						d.reason = tmcr_pkg::WHY_NO_CHILD;
						d.hop = first;
					end else begin
						d.path_len = plen - 3'd1;
						d.path = trim_path(d.path >> 3, d.path_len);
						d.action = tmcr_pkg::ACT_CHILD;
						d.hop = first;
						d.accepted = 1'b1;
					end
				end
			end
		endcase
		d.count = 3'(slot_count);
		d.full = slot_count >= cap;
		return d;
	endfunction

	task automatic write_reg(input logic idx, input logic [63:0] value);
		logic [63:0] expected;
		if (idx == tmcr_pkg::REG_HAS_PARENT) begin
			expected = {63'd0, value[0]};
		end else begin
			expected = {16'd0, value[47:0]};
		end
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// Read the register back right after the write.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== expected) begin
			if (mismatches < 10) begin
				$display("register read mismatch: expected %h actual %h", expected, prdata);
			end
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == tmcr_pkg::REG_HAS_PARENT) begin
			node_has_parent = value[0];
		end else begin
			node_parent_mac = value[47:0];
		end
		@(posedge clk);
	endtask

	// Offers one command and records its decision once the transfer happens.
	// tvalid stays high afterwards so that a following command can go back to back.
	task automatic send_cmd(input tmcr_pkg::cmd_t c, input logic [2:0] idx,
			input logic [47:0] mac, input logic up, input logic [2:0] plen,
			input logic [14:0] hops);
		int        gap;
		decision_t dec;
		gap = tx_idle ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {2'b00, hops, plen, up, mac, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		dec = router_decision(c, idx, mac, up, plen, hops);
		pending_decisions = {pending_decisions, dec};
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_decisions.size() != 0) @(posedge clk);
	endtask

	task automatic test_table_edits();
		wait_drained();
		write_reg(tmcr_pkg::REG_HAS_PARENT, 64'd0);
		write_reg(tmcr_pkg::REG_PARENT_MAC, {16'd0, MAC_ONES});
		send_cmd(tmcr_pkg::CMD_ADD, 3'd1, 48'd0, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_ADD, 3'd6, MAC_ONES, 1'b1, 3'd7, 15'h7FFF);
		send_cmd(tmcr_pkg::CMD_ADD, 3'd0, 48'h5A5A_0000_0001, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_ADD, 3'd7, 48'h5A5A_0000_0001, 1'b0, 3'd0, 15'd0);
		// Duplicate MAC, then a slot that is already taken.
		send_cmd(tmcr_pkg::CMD_ADD, 3'd2, MAC_ONES, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_ADD, 3'd1, 48'h5A5A_0000_0001, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_REMOVE, 3'd3, 48'd0, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_REMOVE, 3'd0, 48'd0, 1'b0, 3'd0, 15'd0);
		send_cmd(tmcr_pkg::CMD_REMOVE, 3'd7, 48'd0, 1'b0, 3'd0, 15'd0);
		for (int k = 2; k <= 5; k++) begin
			send_cmd(tmcr_pkg::CMD_ADD, 3'(k), 48'h5A5A_0000_0000 + 48'(k), 1'b0, 3'd0,
				15'd0);
		end
		// Root node: upstream frame is delivered; hop bits beyond the length are ignored.
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b1, 3'd0, 15'h7FFF);
	endtask

	task automatic test_route_cases();
		wait_drained();
		// Parent MAC equals the child in slot 6, and the count now exceeds capacity.
		write_reg(tmcr_pkg::REG_HAS_PARENT, 64'd1);
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd0, 15'h7FFF);
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b1, 3'd4, 15'h5B6D);
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd2,
			{3'd7, 3'd7, 3'd1, 3'd4, 3'd2});
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd1,
			{3'd5, 3'd5, 3'd5, 3'd5, 3'd0});
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd3,
			{3'd0, 3'd0, 3'd2, 3'd3, 3'd7});
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd6, 15'h1249);
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, 48'd0, 1'b1, 3'd5, 15'h7FFF);
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, 48'd0, 1'b0, 3'd1, {12'd0, 3'd2});
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, 48'h1234_5678_9ABC, 1'b1, 3'd1, {12'd0, 3'd3});
		send_cmd(tmcr_pkg::CMD_REMOVE, 3'd6, 48'd0, 1'b0, 3'd0, 15'd0);
		// The parent alone may not send upstream, and slot 6 is now empty.
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b1, 3'd1, {12'd0, 3'd1});
		send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, MAC_ONES, 1'b0, 3'd1, {12'd0, 3'd6});
		send_cmd(tmcr_pkg::CMD_CLEAR, 3'd5, MAC_ONES, 1'b1, 3'd7, 15'h7FFF);
	endtask

	task automatic test_backpressure();
		wait_drained();
		tx_idle = 1'b0;
		send_cmd(tmcr_pkg::CMD_CLEAR, 3'd0, 48'd0, 1'b0, 3'd0, 15'd0);
		// The result side now holds off while commands keep coming.
		rx_hold = 300;
		for (int k = 0; k < 6; k++) begin
			send_cmd(tmcr_pkg::CMD_ADD, 3'(k + 1), 48'hC0DE_0000_0000 + 48'(k), 1'b0, 3'd0,
				15'd0);
		end
		for (int k = 0; k < 24; k++) begin
			send_cmd(tmcr_pkg::CMD_ROUTE, 3'd0, 48'hC0DE_0000_0000 + 48'(k % 6), 1'b1,
				3'(k % 6), 15'($urandom));
		end
		wait_drained();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [47:0]    pool [12];
		int             r;
		int             k;
		tmcr_pkg::cmd_t c;
		logic [2:0]     idx;
		logic [47:0]    mac;
		logic           up;
		logic [2:0]     plen;
		logic [14:0]    hops;
		pool[0] = 48'd0;
		pool[1] = MAC_ONES;
		for (int p = 2; p < 12; p++) begin
			pool[p] = {16'($urandom), 32'($urandom)};
		end
		for (int ph = 0; ph < 4; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_reg(tmcr_pkg::REG_HAS_PARENT, 64'd0);
					write_reg(tmcr_pkg::REG_PARENT_MAC, {16'd0, pool[2]});
					tx_idle = 1'b1;
					rx_idle = 1'b1;
				end
				1: begin
					write_reg(tmcr_pkg::REG_HAS_PARENT, 64'd1);
					write_reg(tmcr_pkg::REG_PARENT_MAC, {16'd0, pool[1]});
					tx_idle = 1'b0;
					rx_idle = 1'b0;
				end
				2: begin
					write_reg(tmcr_pkg::REG_PARENT_MAC, {16'd0, pool[0]});
					tx_idle = 1'b1;
					rx_idle = 1'b0;
				end
				default: begin
					write_reg(tmcr_pkg::REG_PARENT_MAC, {16'd0, pool[2]});
					tx_idle = 1'b0;
					rx_idle = 1'b1;
				end
			endcase
			for (int n = 0; n < 150; n++) begin
				r = $urandom_range(0, 99);
				c = (r < 20) ? tmcr_pkg::CMD_ADD : (r < 32) ? tmcr_pkg::CMD_REMOVE
					: (r < 35) ? tmcr_pkg::CMD_CLEAR : tmcr_pkg::CMD_ROUTE;
				idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
					: 3'($urandom_range(1, CHILD_SLOTS));
				mac = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
					: pool[$urandom_range(0, 11)];
				up = 1'($urandom_range(0, 1));
				plen = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
					: 3'($urandom_range(0, HOP_LIMIT));
				hops = 15'($urandom);
				if (c == tmcr_pkg::CMD_ROUTE) begin
					// Mostly senders the node knows, so routes get past the binding check.
					k = $urandom_range(0, 9);
					if (k < 4) begin
						k = $urandom_range(0, CHILD_SLOTS - 1);
						if (slot_used[k]) begin
							mac = slot_addr[k];
						end
					end else if (k < 7) begin
						mac = node_parent_mac;
					end
					if (!up && $urandom_range(0, 3) != 0) begin
						hops[2:0] = 3'($urandom_range(1, CHILD_SLOTS));
					end
				end
				send_cmd(c, idx, mac, up, plen, hops);
			end
		end
		rx_idle = 1'b1;
	endtask

	// Result side: random stall before each transfer while rx_idle is set, plus a long hold on request.
	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = rx_idle ? $urandom_range(0, 17) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		decision_t got;
		decision_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.accepted = m_tdata[0];
			got.action   = tmcr_pkg::action_t'(m_tdata[2:1]);
			got.reason   = tmcr_pkg::drop_t'(m_tdata[4:3]);
			got.hop      = m_tdata[7:5];
			got.path_len = m_tdata[10:8];
			got.path     = m_tdata[25:11];
			got.count    = m_tdata[28:26];
			got.full     = m_tdata[29];
			if (pending_decisions.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected result transfer: m_tdata=%h", m_tdata);
				end
				mismatches++;
			end else begin
				want = pending_decisions.pop_front();
				if (got.accepted !== want.accepted || got.action !== want.action ||
						got.reason !== want.reason || got.hop !== want.hop ||
						got.path_len !== want.path_len || got.path !== want.path ||
						got.count !== want.count || got.full !== want.full) begin
					if (mismatches < 10) begin
						$display("result mismatch: expected acc=%0d act=%0d why=%0d hop=%0d",
							want.accepted, want.action, want.reason, want.hop,
							" len=%0d path=%h cnt=%0d full=%0d", want.path_len, want.path,
							want.count, want.full);
						$display("                 actual   acc=%0d act=%0d why=%0d hop=%0d",
							got.accepted, got.action, got.reason, got.hop,
							" len=%0d path=%h cnt=%0d full=%0d", got.path_len, got.path,
							got.count, got.full);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("tree_mesh_child_table_router test failed");
		$finish;
	end

	initial begin : main
		slot_used = '{default: 1'b0};
		slot_addr = '{default: 48'd0};
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_edits();
		test_route_cases();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_decisions.size() == 0) begin
			$display("tree_mesh_child_table_router test passed");
		end else begin
			$display("tree_mesh_child_table_router test failed");
		end
		$finish;
	end

endmodule

[files.f]
design/tmcr_pkg.sv
design/tmcr_mac_ram.sv
design/tree_mesh_child_table_router.sv
tb/sv/tb_tree_mesh_child_table_router.sv
